@@ hdl/vertex_attribute_dedup_top_assert.svh @@
// ----------------------------------------------------------------------------
// Vertex attribute dedup assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ATTRIBUTE_DEDUP_TOP_ASSERT_SVH
`define VERTEX_ATTRIBUTE_DEDUP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VAD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/vad_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex attribute dedup package
// Table geometry, field widths and register map shared by the block and its
// channel interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vad_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int WORD_W      = 32;
    localparam int VI_W        = 10;
    localparam int KEY_W       = 8 * WORD_W;

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    typedef enum logic
    {
        REG_NORMALS_PRESENT   = 1'b0,
        REG_TEXCOORDS_PRESENT = 1'b1
    } reg_idx_t;

endpackage

@@ hdl/vad_in_if.sv @@
// ----------------------------------------------------------------------------
// Vertex input channel
// Valid/ready channel carrying one resolved vertex per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vad_in_if
    import vad_pkg::*;
();

    logic              valid;
    logic              ready;
    logic              first_of_mesh;
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_z;
    logic [WORD_W-1:0] normal_x;
    logic [WORD_W-1:0] normal_y;
    logic [WORD_W-1:0] normal_z;
    logic [WORD_W-1:0] tex_u;
    logic [WORD_W-1:0] tex_v;

    modport source
    (
        output valid, first_of_mesh, pos_x, pos_y, pos_z,
               normal_x, normal_y, normal_z, tex_u, tex_v,
        input  ready
    );

    modport sink
    (
        input  valid, first_of_mesh, pos_x, pos_y, pos_z,
               normal_x, normal_y, normal_z, tex_u, tex_v,
        output ready
    );

endinterface

@@ hdl/vad_out_if.sv @@
// ----------------------------------------------------------------------------
// Dedup result channel
// Valid/ready channel carrying one table lookup result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vad_out_if
    import vad_pkg::*;
();

    logic            valid;
    logic            ready;
    logic [VI_W-1:0] vertex_index;
    logic            is_new;
    logic            table_full;

    modport source
    (
        output valid, vertex_index, is_new, table_full,
        input  ready
    );

    modport sink
    (
        input  valid, vertex_index, is_new, table_full,
        output ready
    );

endinterface

@@ hdl/vertex_attribute_dedup_top.sv @@
// ----------------------------------------------------------------------------
// Vertex attribute dedup
// Searches a table of unique vertices in insertion order for a bitwise match,
// appends the vertex when none is found and room is left, and returns its index.
//
//   Channel   Dir   Beat / access
//   vertex    in    one vertex: mesh start flag, position, normal, texcoord
//   result    out   vertex_index, is_new, table_full
//   APB       in    normals_present at 0x0, texcoords_present at 0x4
//
// The search is bound by one read per cycle of the vertex memory. Reset
// empties the table and clears both registers; no clearing pass runs. A
// result waits in the output register while the next vertex is accepted; the
// search of that vertex holds before writing its result until the output
// register has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vertex_attribute_dedup_top_assert.svh"

module vertex_attribute_dedup_top
    import vad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    vad_in_if.sink                vertex,
    vad_out_if.source             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } state_t;

    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [CNT_W-1:0] scan_reg,   scan_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg;
    logic             out_valid_reg, out_valid_next;
    logic             nrm_en_reg, tex_en_reg;

    logic [KEY_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic             res_new_reg, res_new_next;
    logic             res_full_reg, res_full_next;
    logic [VI_W-1:0]  out_idx_reg;
    logic             out_new_reg, out_full_reg;

    logic [KEY_W-1:0] mem [TABLE_DEPTH];
    logic [KEY_W-1:0] rdata_reg;
    logic             mem_re, mem_we;

    logic             in_fire, cfg_wr, hit, scan_done, out_free, emit_go;
    logic [WORD_W-1:0] nx, ny, nz, tu, tv;

    assign in_fire   = vertex.valid && vertex.ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || result.ready;
    assign hit       = chk_valid_reg && (rdata_reg == key_reg);
    assign scan_done = !chk_valid_reg && (scan_reg == cnt_reg);
    assign mem_re    = (state_reg == S_SEARCH) && !hit && (scan_reg < cnt_reg);
    assign emit_go   = (state_reg == S_EMIT) && out_free;
    assign mem_we    = emit_go && res_new_reg;

    assign nx = nrm_en_reg ? vertex.normal_x : '0;
    assign ny = nrm_en_reg ? vertex.normal_y : '0;
    assign nz = nrm_en_reg ? vertex.normal_z : '0;
    assign tu = tex_en_reg ? vertex.tex_u : '0;
    assign tv = tex_en_reg ? vertex.tex_v : '0;

    assign vertex.ready        = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.vertex_index = out_idx_reg;
    assign result.is_new       = out_new_reg;
    assign result.table_full   = out_full_reg;

    assign pready = 1'b1;

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_NORMALS_PRESENT:   prdata = {{(APB_DATA_W-1){1'b0}}, nrm_en_reg};
            REG_TEXCOORDS_PRESENT: prdata = {{(APB_DATA_W-1){1'b0}}, tex_en_reg};
            default:               prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        chk_valid_next = mem_re;
        out_valid_next = out_valid_reg && !result.ready;
        key_next       = key_reg;
        res_idx_next   = res_idx_reg;
        res_new_next   = res_new_reg;
        res_full_next  = res_full_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    key_next   = {tu, tv, ny, nz, vertex.pos_z, nx,
                                  vertex.pos_x, vertex.pos_y};
                    scan_next  = '0;
                    if (vertex.first_of_mesh)
                    begin
                        cnt_next = '0;
                    end
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    res_idx_next  = chk_idx_reg;
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = S_EMIT;
                end
                else if (scan_done)
                begin
                    if (cnt_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        res_idx_next  = '0;
                        res_new_next  = 1'b0;
                        res_full_next = 1'b1;
                    end
                    else
                    begin
                        res_idx_next  = cnt_reg[IDX_W-1:0];
                        res_new_next  = 1'b1;
                        res_full_next = 1'b0;
                    end
                    state_next = S_EMIT;
                end
                else if (mem_re)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (res_new_reg)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            nrm_en_reg    <= 1'b0;
            tex_en_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr && (reg_idx_t'(paddr[2]) == REG_NORMALS_PRESENT))
            begin
                nrm_en_reg <= pwdata[0];
            end
            if (cfg_wr && (reg_idx_t'(paddr[2]) == REG_TEXCOORDS_PRESENT))
            begin
                tex_en_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        res_idx_reg  <= res_idx_next;
        res_new_reg  <= res_new_next;
        res_full_reg <= res_full_next;
        if (mem_re)
        begin
            chk_idx_reg <= scan_reg[IDX_W-1:0];
        end
        if (emit_go)
        begin
            out_idx_reg  <= VI_W'(res_idx_reg);
            out_new_reg  <= res_new_reg;
            out_full_reg <= res_full_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= key_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[scan_reg[IDX_W-1:0]];
        end
    end

    `VAD_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(TABLE_DEPTH),
        "Unique count exceeds the table depth.")

    `VAD_ASSERT_SAME(a_append_room, clk, rst_n, mem_we, cnt_reg < CNT_W'(TABLE_DEPTH),
        "Append issued into a full table.")

    `VAD_ASSERT_NEXT(a_append_count, clk, rst_n, mem_we,
        cnt_reg == $past(cnt_reg) + CNT_W'(1),
        "Unique count did not advance after an append.")

    `VAD_ASSERT_SAME(a_check_in_range, clk, rst_n, chk_valid_reg,
        (state_reg == S_SEARCH) && ({1'b0, chk_idx_reg} < cnt_reg),
        "Pending compare lies outside the searched entries.")

    `VAD_ASSERT_SAME(a_full_result, clk, rst_n, out_valid_reg && out_full_reg,
        !out_new_reg && (out_idx_reg == '0),
        "Full-table result carries an index or a new flag.")

endmodule

@@ verif/tb_vertex_attribute_dedup_top.sv @@
// ----------------------------------------------------------------------------
// Vertex attribute dedup testbench
// Drives resolved vertices into the block and checks every lookup result
// against a table of unique vertices kept by the testbench itself. Directed
// beats cover signed zeros, NaN patterns and ignored attributes, and a fill
// phase runs the table up to its limit. Random meshes follow under every
// register setting, with random idle bursts on both channels in all but the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_vertex_attribute_dedup_top
    import vad_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 6000;

    typedef struct packed
    {
        logic              first_of_mesh;
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] normal_x;
        logic [WORD_W-1:0] normal_y;
        logic [WORD_W-1:0] normal_z;
        logic [WORD_W-1:0] tex_u;
        logic [WORD_W-1:0] tex_v;
    } vertex_t;

    typedef struct packed
    {
        logic [VI_W-1:0] vertex_index;
        logic            is_new;
        logic            table_full;
    } dedup_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    vad_in_if  vertex_ch();
    vad_out_if result_ch();

    vertex_attribute_dedup_top DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .vertex  (vertex_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [KEY_W-1:0] unique_keys [TABLE_DEPTH];
    int               unique_total;
    logic             normals_on;
    logic             tex_on;

    vertex_t          pending_vertices [$];
    dedup_result_t    expected_results [$];
    vertex_t          beat_on_bus;
    vertex_t          fill_set [TABLE_DEPTH];
    int               vertices_queued;
    int               results_checked;
    int               mismatch_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               send_gap;
    int               recv_gap;
    int               stall_cycles;

    function automatic dedup_result_t lookup_vertex(vertex_t v);
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] nx;
        logic [WORD_W-1:0] ny;
        logic [WORD_W-1:0] nz;
        logic [WORD_W-1:0] tu;
        logic [WORD_W-1:0] tv;
        dedup_result_t     r;
        if (v.first_of_mesh)
            unique_total = 0;
        nx = normals_on ? v.normal_x : 32'h0;
        ny = normals_on ? v.normal_y : 32'h0;
        nz = normals_on ? v.normal_z : 32'h0;
        tu = tex_on ? v.tex_u : 32'h0;
        tv = tex_on ? v.tex_v : 32'h0;
        key = {v.pos_x, v.pos_y, v.pos_z, nx, ny, nz, tu, tv};
        r = '0;
        for (int j = 0; j < unique_total; j++)
        begin
            if (unique_keys[j] == key)
            begin
                r.vertex_index = VI_W'(j);
                return r;
            end
        end
        if (unique_total >= TABLE_DEPTH)
        begin
            r.table_full = 1'b1;
            return r;
        end
        unique_keys[unique_total] = key;
        r.vertex_index = VI_W'(unique_total);
        r.is_new = 1'b1;
        unique_total++;
        return r;
    endfunction

    function automatic vertex_t make_vertex(logic first, logic [WORD_W-1:0] px,
                                            logic [WORD_W-1:0] py, logic [WORD_W-1:0] pz,
                                            logic [WORD_W-1:0] nx, logic [WORD_W-1:0] ny,
                                            logic [WORD_W-1:0] nz, logic [WORD_W-1:0] tu,
                                            logic [WORD_W-1:0] tv);
        vertex_t v;
        v = '{first, px, py, pz, nx, ny, nz, tu, tv};
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = 32'h0000_0000;
            1:       w = 32'h8000_0000;
            2:       w = 32'h7FC0_0000;
            3:       w = 32'h7F80_0000;
            4:       w = 32'hFFFF_FFFF;
            5:       w = 32'h3F80_0000;
            default: w = $urandom();
        endcase
        return w;
    endfunction

    task automatic queue_vertex(vertex_t v);
        pending_vertices.push_back(v);
        vertices_queued++;
    endtask

    task automatic drain();
        while (results_checked != vertices_queued)
            @(posedge clk);
    endtask

    task automatic write_register(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_NORMALS_PRESENT)
            normals_on = value[0];
        else
            tex_on = value[0];
    endtask

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
    endtask

    // Meshes are short runs that start with first_of_mesh and mostly reuse
    // their own vertices, so that hits, near misses and appends all occur.
    task automatic queue_meshes(int count, logic vary_idle);
        vertex_t mesh_verts [$];
        vertex_t v;
        int      mesh_left;
        int      roll;
        int      bit_pos;
        logic    starts_mesh;
        mesh_left = 0;
        for (int n = 0; n < count; n++)
        begin
            while (pending_vertices.size() >= 4)
                @(posedge clk);
            if (vary_idle && n % 32 == 0)
            begin
                send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
                recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
            end
            starts_mesh = (mesh_left == 0);
            if (starts_mesh)
            begin
                mesh_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 30);
                mesh_verts.delete();
            end
            roll = $urandom_range(0, 99);
            if (mesh_verts.size() > 0 && roll < 45)
            begin
                v = mesh_verts[$urandom_range(0, mesh_verts.size() - 1)];
                if (!normals_on)
                begin
                    v.normal_x = $urandom();
                    v.normal_y = $urandom();
                    v.normal_z = $urandom();
                end
                if (!tex_on)
                begin
                    v.tex_u = $urandom();
                    v.tex_v = $urandom();
                end
            end
            else if (mesh_verts.size() > 0 && roll < 60)
            begin
                v = mesh_verts[$urandom_range(0, mesh_verts.size() - 1)];
                bit_pos = $urandom_range(0, KEY_W - 1);
                v[bit_pos] = ~v[bit_pos];
                mesh_verts.push_back(v);
            end
            else
            begin
                v = make_vertex(1'b0, pick_word(), pick_word(), pick_word(), pick_word(),
                                pick_word(), pick_word(), pick_word(), pick_word());
                mesh_verts.push_back(v);
            end
            v.first_of_mesh = starts_mesh;
            queue_vertex(v);
            mesh_left--;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            vertex_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (vertex_ch.valid && vertex_ch.ready)
                expected_results.push_back(lookup_vertex(beat_on_bus));
            if (!vertex_ch.valid || vertex_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    vertex_ch.valid <= 1'b0;
                end
                else if (pending_vertices.size() > 0 &&
                         $urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap = $urandom_range(0, 16);
                    vertex_ch.valid <= 1'b0;
                end
                else if (pending_vertices.size() > 0)
                begin
                    beat_on_bus = pending_vertices.pop_front();
                    vertex_ch.first_of_mesh <= beat_on_bus.first_of_mesh;
                    vertex_ch.pos_x         <= beat_on_bus.pos_x;
                    vertex_ch.pos_y         <= beat_on_bus.pos_y;
                    vertex_ch.pos_z         <= beat_on_bus.pos_z;
                    vertex_ch.normal_x      <= beat_on_bus.normal_x;
                    vertex_ch.normal_y      <= beat_on_bus.normal_y;
                    vertex_ch.normal_z      <= beat_on_bus.normal_z;
                    vertex_ch.tex_u         <= beat_on_bus.tex_u;
                    vertex_ch.tex_v         <= beat_on_bus.tex_v;
                    vertex_ch.valid         <= 1'b1;
                end
                else
                begin
                    vertex_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        dedup_result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, expected none, actual %0h/%0b/%0b",
                             $time, result_ch.vertex_index, result_ch.is_new,
                             result_ch.table_full);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_ch.vertex_index !== want.vertex_index)
                        report_mismatch("vertex_index", 32'(want.vertex_index),
                                        32'(result_ch.vertex_index));
                    if (result_ch.is_new !== want.is_new)
                        report_mismatch("is_new", 32'(want.is_new), 32'(result_ch.is_new));
                    if (result_ch.table_full !== want.table_full)
                        report_mismatch("table_full", 32'(want.table_full),
                                        32'(result_ch.table_full));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                result_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < recv_idle_pct)
            begin
                recv_gap = $urandom_range(0, 16);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((vertex_ch.valid && vertex_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        vertex_t v;
        int      bit_pos;
        logic [WORD_W-1:0] w;

        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        vertex_ch.valid        = 1'b0;
        vertex_ch.first_of_mesh = 1'b0;
        vertex_ch.pos_x        = '0;
        vertex_ch.pos_y        = '0;
        vertex_ch.pos_z        = '0;
        vertex_ch.normal_x     = '0;
        vertex_ch.normal_y     = '0;
        vertex_ch.normal_z     = '0;
        vertex_ch.tex_u        = '0;
        vertex_ch.tex_v        = '0;
        result_ch.ready        = 1'b0;
        unique_total           = 0;
        normals_on             = 1'b0;
        tex_on                 = 1'b0;
        vertices_queued        = 0;
        results_checked        = 0;
        mismatch_count         = 0;
        send_idle_pct          = 20;
        recv_idle_pct          = 20;
        stall_cycles           = 0;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // Both attributes ignored: signed zeros and NaN patterns are distinct
        // keys, while normal and texture fields must not matter.
        queue_vertex(make_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_vertex(make_vertex(0, 0, 0, 0, '1, '1, '1, '1, '1));
        queue_vertex(make_vertex(0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0));
        queue_vertex(make_vertex(0, '1, '1, '1, 0, 0, 0, 0, 0));
        queue_vertex(make_vertex(0, 32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000,
                                 0, 0, 0, 0, 0));
        queue_vertex(make_vertex(0, '1, '1, '1, 32'h1234_5678, 0, 0, 32'h0BAD_F00D, 0));
        drain();

        write_register(REG_NORMALS_PRESENT, 32'hFFFF_FFFF);
        write_register(REG_TEXCOORDS_PRESENT, 32'h0000_0001);
        queue_vertex(make_vertex(1, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_vertex(make_vertex(0, '1, '1, '1, '1, '1, '1, '1, '1));
        queue_vertex(make_vertex(0, '1, '1, '1, '1, '1, '1, '1, '1));
        queue_vertex(make_vertex(0, '1, '1, '1, '1, '1, '1, '1, 32'hFFFF_FFFE));
        queue_vertex(make_vertex(0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
        queue_vertex(make_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_vertex(make_vertex(1, '1, '1, '1, '1, '1, '1, '1, '1));
        queue_vertex(make_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        write_register(REG_NORMALS_PRESENT, 32'hFFFF_FFFE);
        queue_vertex(make_vertex(0, 0, 0, 0, '1, '1, '1, 0, 0));
        queue_vertex(make_vertex(0, '1, '1, '1, '1, '1, '1, '1, '1));
        drain();

        // Fill the table to its last entry. The low bits of pos_x keep every
        // entry distinct, so afterwards fresh vertices find no room.
        write_register(REG_NORMALS_PRESENT, 32'h8000_0001);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            w = $urandom();
            w[VI_W-1:0] = VI_W'(i);
            fill_set[i] = make_vertex(i == 0, w, pick_word(), pick_word(), pick_word(),
                                      pick_word(), pick_word(), pick_word(), pick_word());
            queue_vertex(fill_set[i]);
        end
        repeat (3)
        begin
            v = fill_set[$urandom_range(0, TABLE_DEPTH - 1)];
            v.first_of_mesh = 1'b0;
            bit_pos = $urandom_range(0, 5 * WORD_W - 1);
            v[bit_pos] = ~v[bit_pos];
            queue_vertex(v);
        end
        queue_vertex(fill_set[TABLE_DEPTH - 1]);
        v = fill_set[0];
        v.first_of_mesh = 1'b0;
        queue_vertex(v);
        queue_vertex(fill_set[$urandom_range(1, TABLE_DEPTH - 1)]);

        for (int seg = 0; seg < 4; seg++)
        begin
            drain();
            write_register(REG_NORMALS_PRESENT, ($urandom() & ~32'h1) | 32'(seg & 1));
            write_register(REG_TEXCOORDS_PRESENT, ($urandom() & ~32'h1) | 32'((seg >> 1) & 1));
            if (seg == 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_meshes(145, seg != 3);
        end
        drain();

        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
